>>> hdl/box_average_downscale_assert.svh
// assertion macros for the box average downscaler
`ifndef BOX_AVERAGE_DOWNSCALE_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALE_ASSERT_SVH

// checked outside reset
`define BAD_ASSERT(lbl, pr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pr) else $error(msg);

// checked at every edge, reset included
`define BAD_ASSERT_ALWAYS(lbl, pr, msg) \
  lbl: assert property (@(posedge clk) pr) else $error(msg);

`endif

>>> hdl/bad_pkg.sv
package bad_pkg;

  localparam int DIM_W     = 13;
  localparam int OUT_DIM_W = 12;
  localparam int POS_W     = 13;
  localparam int COORD_W   = 11;
  localparam int CFG_IDX_W = 3;
  localparam int REM_STEPS = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic [7:0]         out_alpha;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               size_error;
  } out_pixel_t;

  typedef enum logic [2:0] {
    ST_SCALE,
    ST_REM,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic scale_init;
    logic scale_step;
    logic rem_init;
    logic rem_step;
    logic accept;
    logic mem_write;
    logic div_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic reject_now;
    logic use_px;
    logic last_px;
  } dp_sts_t;

endpackage

>>> hdl/bad_ctrl.sv
module bad_ctrl #(
  parameter int MAX_SCALE = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               cfg_ready,
  input  bad_pkg::dp_sts_t   sts,
  output bad_pkg::ctrl_cmd_t cmd
);

  localparam int SUMW = $clog2(MAX_SCALE * MAX_SCALE * 255 + 1);
  localparam int CNTW = $clog2(SUMW + MAX_SCALE + bad_pkg::REM_STEPS + 4);

  bad_pkg::state_t state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic            last, last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bad_pkg::ST_SCALE;
      cnt   <= '0;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      last  <= last_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    last_next  = last;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cfg_ready  = 1'b1;
    case (state)
      bad_pkg::ST_SCALE: begin
        cmd.scale_init = (cnt == '0);
        cmd.scale_step = (cnt != '0);
        if (cnt == CNTW'(MAX_SCALE + 1)) begin
          state_next = bad_pkg::ST_REM;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bad_pkg::ST_REM: begin
        cmd.rem_init = (cnt == '0);
        cmd.rem_step = (cnt != '0);
        if (cnt == CNTW'(bad_pkg::REM_STEPS)) begin
          state_next = bad_pkg::ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bad_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          last_next  = sts.last_px;
          if (sts.reject_now) begin
            state_next = bad_pkg::ST_OUT;
          end else if (sts.use_px) begin
            state_next = bad_pkg::ST_READ;
          end
        end
      end
      bad_pkg::ST_READ: begin
        state_next = bad_pkg::ST_WRITE;
      end
      bad_pkg::ST_WRITE: begin
        cmd.mem_write = 1'b1;
        cnt_next      = '0;
        state_next    = last ? bad_pkg::ST_DIV : bad_pkg::ST_IDLE;
      end
      bad_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNTW'(SUMW - 1)) begin
          state_next = bad_pkg::ST_OUT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bad_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = bad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bad_pkg::ST_SCALE;
        cnt_next   = '0;
      end
    endcase
    if (sts.cfg_hit) begin
      state_next = bad_pkg::ST_SCALE;
      cnt_next   = '0;
    end
  end

endmodule

>>> hdl/bad_dp.sv
module bad_dp #(
  parameter int MAX_OUT_WIDTH = 2048,
  parameter int MAX_IN_WIDTH  = 4096,
  parameter int MAX_SCALE     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bad_pkg::ctrl_cmd_t                  cmd,
  output bad_pkg::dp_sts_t                    sts,
  input  logic                                cfg_valid,
  input  logic [bad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bad_pkg::DIM_W-1:0]           cfg_data,
  input  bad_pkg::in_pixel_t                  in_data,
  output bad_pkg::out_pixel_t                 out_data
);

  localparam int SW   = $clog2(MAX_SCALE + 2);
  localparam int PW   = bad_pkg::OUT_DIM_W + SW;
  localparam int AW   = 2 * SW;
  localparam int SUMW = $clog2(MAX_SCALE * MAX_SCALE * 255 + 1);
  localparam int IW   = $clog2(MAX_OUT_WIDTH);
  localparam int DW   = bad_pkg::DIM_W;
  localparam int OW   = bad_pkg::OUT_DIM_W;
  localparam int PSW  = bad_pkg::POS_W;

  logic [DW-1:0] in_w, in_h;
  logic [OW-1:0] out_w, out_h;
  logic          cfg_hit;

  assign cfg_hit = cfg_valid && (cfg_index <= bad_pkg::REG_OUT_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_w  <= DW'(1);
      in_h  <= DW'(1);
      out_w <= OW'(1);
      out_h <= OW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        bad_pkg::REG_IN_WIDTH:   in_w  <= cfg_data;
        bad_pkg::REG_IN_HEIGHT:  in_h  <= cfg_data;
        bad_pkg::REG_OUT_WIDTH:  out_w <= cfg_data[OW-1:0];
        bad_pkg::REG_OUT_HEIGHT: out_h <= cfg_data[OW-1:0];
        default: ;
      endcase
    end
  end

  // scale search by repeated addition
  logic [PW-1:0] prod_w, prod_h;
  logic [SW-1:0] cnt_w, cnt_h;

  always_ff @(posedge clk) begin
    if (cmd.scale_init) begin
      prod_w <= PW'(out_w);
      prod_h <= PW'(out_h);
      cnt_w  <= '0;
      cnt_h  <= '0;
    end else if (cmd.scale_step) begin
      if (prod_w <= PW'(in_w)) cnt_w <= cnt_w + 1'b1;
      if (prod_h <= PW'(in_h)) cnt_h <= cnt_h + 1'b1;
      prod_w <= prod_w + PW'(out_w);
      prod_h <= prod_h + PW'(out_h);
    end
  end

  logic cfg_ok;
  assign cfg_ok = (out_w != '0) && (out_h != '0) &&
                  (32'(out_w) <= MAX_OUT_WIDTH) && (32'(in_w) <= MAX_IN_WIDTH) &&
                  (cnt_w != '0) && (32'(cnt_w) <= MAX_SCALE) && (cnt_h == cnt_w);

  // leftover remainders, one bit a cycle
  logic [DW-1:0] sh_w, sh_h;
  logic [SW-1:0] rw, rh;
  logic [AW-1:0] area;
  logic [SW:0]   rw2, rh2, rw_sub, rh_sub;

  assign rw2    = {rw, sh_w[DW-1]};
  assign rh2    = {rh, sh_h[DW-1]};
  assign rw_sub = rw2 - {1'b0, cnt_w};
  assign rh_sub = rh2 - {1'b0, cnt_w};

  always_ff @(posedge clk) begin
    if (cmd.rem_init) begin
      sh_w <= in_w;
      sh_h <= in_h;
      rw   <= '0;
      rh   <= '0;
      area <= AW'(cnt_w) * AW'(cnt_w);
    end else if (cmd.rem_step) begin
      sh_w <= sh_w << 1;
      sh_h <= sh_h << 1;
      rw   <= (rw2 >= {1'b0, cnt_w}) ? rw_sub[SW-1:0] : rw2[SW-1:0];
      rh   <= (rh2 >= {1'b0, cnt_w}) ? rh_sub[SW-1:0] : rh2[SW-1:0];
    end
  end

  logic [SW-1:0] ex, ey, scale_m1;
  assign ex       = rw >> 1;
  assign ey       = rh >> 1;
  assign scale_m1 = cnt_w - 1'b1;

  // frame position
  logic [PSW-1:0] c, r, ox, oy;
  logic [SW-1:0]  m, q;
  logic           rejected;
  logic           col_wrap, row_wrap, in_x, in_y, reject_now, use_px;

  assign col_wrap   = (32'(c) + 1 >= 32'(in_w));
  assign row_wrap   = (32'(r) + 1 >= 32'(in_h));
  assign in_x       = (c >= PSW'(ex));
  assign in_y       = (r >= PSW'(ey));
  assign reject_now = !cfg_ok && !rejected;
  assign use_px     = cfg_ok && !rejected && in_x && in_y &&
                      (32'(ox) < 32'(out_w)) && (32'(oy) < 32'(out_h)) &&
                      (32'(ox) < MAX_OUT_WIDTH);

  assign sts.cfg_hit    = cfg_hit;
  assign sts.reject_now = reject_now;
  assign sts.use_px     = use_px;
  assign sts.last_px    = (m == scale_m1) && (q == scale_m1);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      c        <= '0;
      r        <= '0;
      m        <= '0;
      q        <= '0;
      ox       <= '0;
      oy       <= '0;
      rejected <= 1'b0;
    end else if (cmd.accept) begin
      if (reject_now) rejected <= 1'b1;
      if (col_wrap) begin
        c  <= '0;
        m  <= '0;
        ox <= '0;
        if (row_wrap) begin
          r        <= '0;
          q        <= '0;
          oy       <= '0;
          rejected <= 1'b0;
        end else begin
          r <= r + 1'b1;
          if (in_y) begin
            if (q == scale_m1) begin
              q  <= '0;
              oy <= oy + 1'b1;
            end else begin
              q <= q + 1'b1;
            end
          end
        end
      end else begin
        c <= c + 1'b1;
        if (in_x) begin
          if (m == scale_m1) begin
            m  <= '0;
            ox <= ox + 1'b1;
          end else begin
            m <= m + 1'b1;
          end
        end
      end
    end
  end

  // request capture
  logic [2:0][7:0]              px;
  logic                         first, err;
  logic [IW-1:0]                addr;
  logic [bad_pkg::COORD_W-1:0]  col, row;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px    <= {in_data.in_red, in_data.in_green, in_data.in_blue};
      first <= (m == '0) && (q == '0);
      err   <= reject_now;
      addr  <= ox[IW-1:0];
      col   <= ox[bad_pkg::COORD_W-1:0];
      row   <= oy[bad_pkg::COORD_W-1:0];
    end
  end

  // column sums
  logic [3*SUMW-1:0]  mem [MAX_OUT_WIDTH];
  logic [3*SUMW-1:0]  rd;
  logic [2:0][SUMW-1:0] sum_new, dvd, dvd_next;
  logic [2:0][AW-1:0]   drem, drem_next;
  logic [AW:0]          r2, r2_sub;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_new[k] = first ? SUMW'(px[k]) : rd[k*SUMW +: SUMW] + SUMW'(px[k]);
    end
  end

  always_comb begin
    r2     = '0;
    r2_sub = '0;
    for (int k = 0; k < 3; k++) begin
      r2     = {drem[k], dvd[k][SUMW-1]};
      r2_sub = r2 - {1'b0, area};
      if (r2 >= {1'b0, area}) begin
        drem_next[k] = r2_sub[AW-1:0];
        dvd_next[k]  = {dvd[k][SUMW-2:0], 1'b1};
      end else begin
        drem_next[k] = r2[AW-1:0];
        dvd_next[k]  = {dvd[k][SUMW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[addr];
    if (cmd.mem_write) begin
      mem[addr] <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      dvd  <= sum_new;
      drem <= '0;
    end else if (cmd.div_step) begin
      dvd  <= dvd_next;
      drem <= drem_next;
    end
  end

  always_comb begin
    out_data = '0;
    if (err) begin
      out_data.size_error = 1'b1;
    end else begin
      out_data.out_red   = dvd[2][7:0];
      out_data.out_green = dvd[1][7:0];
      out_data.out_blue  = dvd[0][7:0];
      out_data.out_alpha = bad_pkg::ALPHA_OPAQUE;
      out_data.out_col   = col;
      out_data.out_row   = row;
    end
  end

endmodule

>>> hdl/box_average_downscale.sv
// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
// pixel in  in         in_valid/in_ready    in_data (in_pixel_t)
// pixel out out        out_valid/out_ready  out_data (out_pixel_t)
//
// after reset or a write to a mapped register: scale search, then crop remainder setup
// pixel outside a used block: IDLE; inside: IDLE, READ, WRITE (column sum read-modify-write)
// block-closing pixel: as inside, then DIV (one quotient bit a cycle), then OUT and output wait
// frame error: IDLE, then OUT, plus output wait
// a stalled output holds the block; no new pixel is taken until it leaves
module box_average_downscale #(
  parameter int MAX_OUT_WIDTH = 2048,
  parameter int MAX_IN_WIDTH  = 4096,
  parameter int MAX_SCALE     = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bad_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bad_pkg::in_pixel_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bad_pkg::out_pixel_t           out_data
);

  bad_pkg::ctrl_cmd_t cmd;
  bad_pkg::dp_sts_t   sts;

  bad_ctrl #(
    .MAX_SCALE(MAX_SCALE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bad_dp #(
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
    .MAX_IN_WIDTH (MAX_IN_WIDTH),
    .MAX_SCALE    (MAX_SCALE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data)
  );

endmodule

>>> hdl/bad_checker.sv
`include "box_average_downscale_assert.svh"

module bad_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bad_pkg::out_pixel_t out_data
);

  `BAD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output request dropped")
  `BAD_ASSERT(a_alpha, out_valid && !out_data.size_error |-> out_data.out_alpha == bad_pkg::ALPHA_OPAQUE, "alpha not opaque")
  `BAD_ASSERT(a_err_blank, out_valid && out_data.size_error |-> out_data.out_red == 8'd0 && out_data.out_green == 8'd0 && out_data.out_blue == 8'd0 && out_data.out_alpha == 8'd0 && out_data.out_col == '0 && out_data.out_row == '0, "error result not blank")
  `BAD_ASSERT(a_one_side, !(in_ready && out_valid), "input taken while result pending")
  `BAD_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid && !in_ready, "activity right after reset")

endmodule

bind box_average_downscale bad_checker u_bad_checker (.*);

>>> verif/box_average_checker.sv
module box_average_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bad_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  bad_pkg::in_pixel_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  bad_pkg::out_pixel_t           out_data,
  output int                            fail_count,
  output int                            pending
);

  localparam int unsigned OUT_LIMIT   = 2048;
  localparam int unsigned IN_LIMIT    = 4096;
  localparam int unsigned SCALE_LIMIT = 16;

  int unsigned in_w, in_h, out_w, out_h;
  int unsigned col_pos, row_pos;
  bit rejected;
  int unsigned column_sums [OUT_LIMIT][3];
  bad_pkg::out_pixel_t expected_pixels [$];

  assign pending = expected_pixels.size();

  initial fail_count = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic restart();
    col_pos = 0;
    row_pos = 0;
    rejected = 0;
  endtask

  task automatic average_pixel(input bad_pkg::in_pixel_t p);
    bad_pkg::out_pixel_t r;
    int unsigned ch [3];
    int unsigned scale, ex, ey, x, y, ox, oy;
    bit ok;
    ch[0] = p.in_red;
    ch[1] = p.in_green;
    ch[2] = p.in_blue;
    scale = 0;
    ok = out_w != 0 && out_h != 0 && out_w <= OUT_LIMIT && in_w <= IN_LIMIT;
    if (ok) begin
      scale = in_w / out_w;
      ok = scale >= 1 && scale <= SCALE_LIMIT && in_h / out_h == scale;
    end
    if (!ok) begin
      if (!rejected) begin
        r = '0;
        r.size_error = 1'b1;
        expected_pixels.push_back(r);
        rejected = 1;
      end
    end else if (!rejected) begin
      ex = (in_w % scale) / 2;
      ey = (in_h % scale) / 2;
      if (col_pos >= ex && row_pos >= ey) begin
        x = col_pos - ex;
        y = row_pos - ey;
        ox = x / scale;
        oy = y / scale;
        if (ox < out_w && oy < out_h && ox < OUT_LIMIT) begin
          for (int k = 0; k < 3; k++) begin
            if (x % scale == 0 && y % scale == 0) column_sums[ox][k] = ch[k];
            else column_sums[ox][k] += ch[k];
          end
          if (x % scale == scale - 1 && y % scale == scale - 1) begin
            r.out_red    = 8'(column_sums[ox][0] / (scale * scale));
            r.out_green  = 8'(column_sums[ox][1] / (scale * scale));
            r.out_blue   = 8'(column_sums[ox][2] / (scale * scale));
            r.out_alpha  = bad_pkg::ALPHA_OPAQUE;
            r.out_col    = (bad_pkg::COORD_W)'(ox);
            r.out_row    = (bad_pkg::COORD_W)'(oy);
            r.size_error = 1'b0;
            expected_pixels.push_back(r);
          end
        end
      end
    end
    if (col_pos + 1 >= in_w) begin
      col_pos = 0;
      if (row_pos + 1 >= in_h) begin
        row_pos = 0;
        rejected = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  task automatic compare_pixel(input bad_pkg::out_pixel_t got);
    bad_pkg::out_pixel_t want;
    if (expected_pixels.size() == 0) begin
      report("unexpected output pixel", 1, 0);
      return;
    end
    want = expected_pixels.pop_front();
    if (got.out_red != want.out_red) report("out_red", got.out_red, want.out_red);
    if (got.out_green != want.out_green) report("out_green", got.out_green, want.out_green);
    if (got.out_blue != want.out_blue) report("out_blue", got.out_blue, want.out_blue);
    if (got.out_alpha != want.out_alpha) report("out_alpha", got.out_alpha, want.out_alpha);
    if (got.out_col != want.out_col) report("out_col", got.out_col, want.out_col);
    if (got.out_row != want.out_row) report("out_row", got.out_row, want.out_row);
    if (got.size_error != want.size_error)
      report("size_error", got.size_error, want.size_error);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_w = 1;
      in_h = 1;
      out_w = 1;
      out_h = 1;
      restart();
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bad_pkg::REG_IN_WIDTH: begin
            in_w = cfg_data;
            restart();
          end
          bad_pkg::REG_IN_HEIGHT: begin
            in_h = cfg_data;
            restart();
          end
          bad_pkg::REG_OUT_WIDTH: begin
            out_w = cfg_data[bad_pkg::OUT_DIM_W-1:0];
            restart();
          end
          bad_pkg::REG_OUT_HEIGHT: begin
            out_h = cfg_data[bad_pkg::OUT_DIM_W-1:0];
            restart();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) average_pixel(in_data);
      if (out_valid && out_ready) compare_pixel(out_data);
    end
  end

endmodule

>>> verif/tb_top.sv
module tb_top;

  localparam logic [bad_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int QUIET_CYCLES = 120;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 600;
  localparam int ITEM_TARGET  = 1300;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [bad_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bad_pkg::DIM_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  bad_pkg::in_pixel_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  bad_pkg::out_pixel_t out_data;

  int fail_count, pending;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_start = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int quiet = 0;
  int pixels_sent = 0;
  int mode = 0;

  always #1 clk = ~clk;

  box_average_downscale u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  box_average_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver side, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_start && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 86; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 86; end
      default: begin send_idle = 33; recv_stall = 33; end
    endcase
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bad_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = (bad_pkg::DIM_W)'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic configure(input int unsigned iw, ih, ow, oh);
    drain();
    write_reg(bad_pkg::REG_IN_WIDTH, iw);
    write_reg(bad_pkg::REG_IN_HEIGHT, ih);
    write_reg(bad_pkg::REG_OUT_WIDTH, ow);
    write_reg(bad_pkg::REG_OUT_HEIGHT, oh);
  endtask

  task automatic push_pixel(input logic [23:0] rgb);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = rgb;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) push_pixel(24'($urandom));
    in_valid = 0;
  endtask

  initial begin
    int unsigned scale, ow, oh, iw, ih, frame;
    int count;
    repeat (11) @(negedge clk);
    rst = 0;

    // scale one: every pixel passes straight through
    push_pixel(24'h000000);
    push_pixel(24'hffffff);
    push_pixel(24'hff00aa);
    push_pixel(24'h55ff00);
    push_pixel(24'h00aa55);
    in_valid = 0;
    // register index outside the map
    drain();
    write_reg(REG_UNUSED, 13'h1fff);
    push_random(2);
    // zero width, zero output size, oversize input, height mismatch
    configure(0, 1, 1, 1);
    push_random(2);
    configure(1, 1, 0, 0);
    push_random(2);
    configure(8191, 2, 4095, 1);
    push_random(2);
    configure(4, 2, 2, 2);
    push_random(8);
    // centered crop on both axes
    configure(8, 8, 3, 3);
    push_pixel(24'hffffff);
    push_random(63);
    // widest legal setting, partial frame
    configure(4096, 4096, 2048, 2048);
    push_random(20);
    configure(2, 2, 1, 1);
    push_pixel(24'hffffff);
    push_pixel(24'hffffff);
    push_pixel(24'hffffff);
    push_pixel(24'hffffff);
    in_valid = 0;

    // fill up behind a stalled receiver
    configure(1, 1, 1, 1);
    hold_start = 1;
    push_random(40);
    hold_start = 0;

    while (pixels_sent < ITEM_TARGET) begin
      set_mode(mode++);
      case ($urandom_range(9))
        0: scale = $urandom_range(5, 16);
        1, 2, 3: scale = 1;
        default: scale = $urandom_range(2, 4);
      endcase
      ow = (scale > 4) ? 1 : $urandom_range(1, 4);
      oh = (scale > 4) ? 1 : $urandom_range(1, 3);
      iw = scale * ow + $urandom_range(scale - 1);
      ih = scale * oh + $urandom_range(scale - 1);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: oh = oh + 1;
          1: iw = 4097 + $urandom_range(4000);
          default: ow = 0;
        endcase
      end
      configure(iw, ih, ow, oh);
      frame = (iw > 64) ? 16 : iw * ih;
      if ($urandom_range(4) == 0) count = $urandom_range(1, frame);
      else count = frame * $urandom_range(1, 2);
      if (count > ITEM_TARGET - pixels_sent) count = ITEM_TARGET - pixels_sent;
      push_random(count);
    end
    set_mode(0);

    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/bad_pkg.sv
hdl/bad_ctrl.sv
hdl/bad_dp.sv
hdl/box_average_downscale.sv
hdl/bad_checker.sv
verif/box_average_checker.sv
verif/tb_top.sv
